### rtl/core/vnf_pkg.sv
// ----------------------------------------------------------------------------
// vnf_pkg: shared types, constants and float helpers for value-noise fBm
// Single-precision add and multiply, split into an unrounded front half
// and a normalize-and-round back half, plus floor and doubling.
// ----------------------------------------------------------------------------
`default_nettype none

package vnf_pkg;

	typedef logic [31:0] vnf_word_t;

	typedef enum logic [1:0] {
		VNF_ADD = 2'd0,
		VNF_SUB = 2'd1,
		VNF_MUL = 2'd2
	} vnf_op_t;

	// Unrounded result: sig has its leading one ideally at bit 47 for exponent ex.
	typedef struct packed {
		logic              spec;
		vnf_word_t         sval;
		logic              sgn;
		logic signed [11:0] ex;
		logic [48:0]       sig;
	} vnf_unr_t;

	localparam int VNF_OCTAVES = 4;
	localparam int VNF_FPU_LAT = 2;
	localparam int VNF_OCT_LAT = 33;

	localparam vnf_word_t VNF_ZERO     = 32'h0000_0000;
	localparam vnf_word_t VNF_ONE      = 32'h3F80_0000;
	localparam vnf_word_t VNF_TWO      = 32'h4000_0000;
	localparam vnf_word_t VNF_THREE    = 32'h4040_0000;
	localparam vnf_word_t VNF_NEG_ONE  = 32'hBF80_0000;
	localparam vnf_word_t VNF_HASH_X   = 32'h42F6_AE14;
	localparam vnf_word_t VNF_HASH_Z   = 32'h43E4_1AE1;
	localparam vnf_word_t VNF_HASH_OFS = 32'h4235_47AE;
	localparam vnf_word_t VNF_QNAN     = 32'h7FC0_0000;
	localparam vnf_word_t VNF_POS_INF  = 32'h7F80_0000;

	// Round to nearest even and pack; s has its leading one at bit 47.
	function automatic vnf_word_t fp_pack(input logic sgn, input int e, input logic [47:0] s);
		logic [47:0] sh;
		logic        st;
		logic [23:0] m;
		logic        g;
		logic        rnd;
		logic [30:0] t;
		int          ee;
		int          n;
		vnf_word_t   r;
		sh = s;
		st = 1'b0;
		ee = e;
		if (e <= 0) begin
			n = 1 - e;
			if (n > 48) begin
				sh = '0;
				st = 1'b1;
			end else begin
				sh = s >> n;
				st = ((sh << n) != s);
			end
			ee = 1;
		end
		m = sh[47:24];
		g = sh[23];
		st = st | (|sh[22:0]);
		rnd = g & (st | m[0]);
		// The rounding carry ripples into the exponent field on its own.
		t = {8'(ee - 1), 23'h0} + {7'h0, m} + {30'h0, rnd};
		if (e >= 255) begin
			r = {sgn, VNF_POS_INF[30:0]};
		end else begin
			r = {sgn, t};
		end
		return r;
	endfunction

	// Back half: find the leading one, normalize and round.
	function automatic vnf_word_t fp_fin(input vnf_unr_t u);
		int          pos;
		int          e;
		logic [47:0] s;
		vnf_word_t   r;
		pos = -1;
		for (int i = 0; i < 49; i++) begin
			if (u.sig[i]) begin
				pos = i;
			end
		end
		s = '0;
		e = 0;
		if (u.spec) begin
			r = u.sval;
		end else if (pos < 0) begin
			r = VNF_ZERO;
		end else begin
			e = int'(u.ex) + pos - 47;
			if (pos == 48) begin
				s = u.sig[48:1] | {47'h0, u.sig[0]};
			end else begin
				s = u.sig[47:0] << (47 - pos);
			end
			r = fp_pack(u.sgn, e, s);
		end
		return r;
	endfunction

	// Front half of add or subtract: special cases, alignment, add.
	function automatic vnf_unr_t fp_add_a(input vnf_word_t a, input vnf_word_t b, input logic sub);
		logic        sb;
		logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		vnf_word_t   bb, big, sml;
		logic [7:0]  eb_big, eb_sml;
		logic [23:0] m_big, m_sml;
		logic [48:0] al, bf, bs;
		logic        st;
		int          d;
		vnf_unr_t    u;
		sb = b[31] ^ sub;
		bb = {sb, b[30:0]};
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 0);
		a_zero = (a[30:0] == 0);
		b_zero = (b[30:0] == 0);
		u = '0;
		u.spec = 1'b1;
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != sb))) begin
			u.sval = VNF_QNAN;
		end else if (a_inf) begin
			u.sval = a;
		end else if (b_inf) begin
			u.sval = bb;
		end else if (a_zero && b_zero) begin
			u.sval = {a[31] & sb, 31'h0};
		end else if (a_zero) begin
			u.sval = bb;
		end else if (b_zero) begin
			u.sval = a;
		end else begin
			u.spec = 1'b0;
			if (b[30:0] > a[30:0]) begin
				big = bb;
				sml = a;
			end else begin
				big = a;
				sml = bb;
			end
			eb_big = (big[30:23] == 0) ? 8'd1 : big[30:23];
			eb_sml = (sml[30:23] == 0) ? 8'd1 : sml[30:23];
			m_big = {big[30:23] != 0, big[22:0]};
			m_sml = {sml[30:23] != 0, sml[22:0]};
			d = int'(eb_big) - int'(eb_sml);
			al = {1'b0, m_big, 24'h0};
			bf = {1'b0, m_sml, 24'h0};
			if (d >= 49) begin
				bs = '0;
				st = 1'b1;
			end else begin
				bs = bf >> d;
				st = ((bs << d) != bf);
			end
			bs[0] = bs[0] | st;
			u.sgn = big[31];
			u.ex = $signed({4'h0, eb_big});
			u.sig = (big[31] == sml[31]) ? (al + bs) : (al - bs);
		end
		return u;
	endfunction

	// Front half of multiply: special cases and the 24 by 24 product.
	function automatic vnf_unr_t fp_mul_a(input vnf_word_t a, input vnf_word_t b);
		logic        s;
		logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		logic [7:0]  ea, eb;
		logic [23:0] ma, mb;
		vnf_unr_t    u;
		s = a[31] ^ b[31];
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 0);
		a_zero = (a[30:0] == 0);
		b_zero = (b[30:0] == 0);
		u = '0;
		u.spec = 1'b1;
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
			u.sval = VNF_QNAN;
		end else if (a_inf || b_inf) begin
			u.sval = {s, VNF_POS_INF[30:0]};
		end else if (a_zero || b_zero) begin
			u.sval = {s, 31'h0};
		end else begin
			u.spec = 1'b0;
			ea = (a[30:23] == 0) ? 8'd1 : a[30:23];
			eb = (b[30:23] == 0) ? 8'd1 : b[30:23];
			ma = {a[30:23] != 0, a[22:0]};
			mb = {b[30:23] != 0, b[22:0]};
			u.sgn = s;
			u.ex = 12'(int'(ea) + int'(eb) - 126);
			u.sig = {1'b0, 48'(ma) * 48'(mb)};
		end
		return u;
	endfunction

	// Exact IEEE floor; large, infinite and NaN values pass unchanged.
	function automatic vnf_word_t fl_floor(input vnf_word_t u);
		logic [7:0]  e;
		logic [23:0] m;
		logic [23:0] iv;
		logic        nz;
		int          sh;
		int          p;
		vnf_word_t   r;
		e = u[30:23];
		m = {1'b1, u[22:0]};
		iv = '0;
		nz = 1'b0;
		sh = 0;
		p = 0;
		if (e >= 8'd150) begin
			r = u;
		end else if (e < 8'd127) begin
			if (u[31] && (u[30:0] != 0)) begin
				r = VNF_NEG_ONE;
			end else begin
				r = {u[31], 31'h0};
			end
		end else begin
			sh = 150 - int'(e);
			iv = m >> sh;
			nz = ((iv << sh) != m);
			if (u[31] && nz) begin
				iv = iv + 24'd1;
			end
			for (int i = 0; i < 24; i++) begin
				if (iv[i]) begin
					p = i;
				end
			end
			r = {u[31], 8'(127 + p), 23'(iv << (23 - p))};
		end
		return r;
	endfunction

	// Multiply by two, which is exact but for overflow.
	function automatic vnf_word_t fp_dbl(input vnf_word_t u);
		vnf_word_t r;
		if (u[30:23] == 8'hFF) begin
			r = u;
		end else if (u[30:23] == 8'h00) begin
			r = {u[31], 7'h0, u[22:0], 1'b0};
		end else if (u[30:23] == 8'hFE) begin
			r = {u[31], VNF_POS_INF[30:0]};
		end else begin
			r = {u[31], u[30:23] + 8'd1, u[22:0]};
		end
		return r;
	endfunction

	// Coordinate of octave k: k successive doublings.
	function automatic vnf_word_t fp_scale(input vnf_word_t u, input int k);
		vnf_word_t r;
		r = u;
		for (int i = 0; i < 8; i++) begin
			if (i < k) begin
				r = fp_dbl(r);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/vnf_in_if.sv
// ----------------------------------------------------------------------------
// vnf_in_if: coordinate channel
// Valid/ready channel carrying one x/z coordinate pair per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface vnf_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_coord;
	logic [31:0] z_coord;

	modport source (output valid, output x_coord, output z_coord, input ready);
	modport sink (input valid, input x_coord, input z_coord, output ready);
endinterface

`default_nettype wire

### rtl/core/vnf_out_if.sv
// ----------------------------------------------------------------------------
// vnf_out_if: noise result channel
// Valid/ready channel carrying one fBm value per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface vnf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

`default_nettype wire

### rtl/core/value_noise_fbm_2d.sv
// A result passes the input stage, the octave pipelines, the weights and the running sum.
// Throughput: one item per cycle unless a waiting result stalls; every octave has its own float pipeline.
// A waiting result stalls the whole pipeline, which then takes no new item.
// Reset clears only the valid bits; the data path carries no state between items.
// ----------------------------------------------------------------------------
// value_noise_fbm_2d: multi-octave 2D value-noise fBm
// Scales the coordinates per octave, runs the octaves side by side, weights
// each octave and sums them in order with single-precision arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module value_noise_fbm_2d #(
	parameter int OCTAVES = vnf_pkg::VNF_OCTAVES
) (
	input logic     clk,
	input logic     arst_n,
	vnf_in_if.sink  coord,
	vnf_out_if.source result
);
	import vnf_pkg::*;

	localparam int LAT = 1 + VNF_OCT_LAT + VNF_FPU_LAT + VNF_FPU_LAT * OCTAVES;

	logic           en;
	logic [LAT-1:0] vld_q;
	vnf_word_t      xs_s1 [OCTAVES];
	vnf_word_t      zs_s1 [OCTAVES];
	vnf_word_t      nv [OCTAVES];
	vnf_word_t      wt [OCTAVES];
	vnf_word_t      wt_d [OCTAVES];
	vnf_word_t      acc [OCTAVES+1];

	// The pipeline advances unless a finished result is waiting and not taken.
	assign en = !vld_q[LAT-1] || result.ready;
	assign coord.ready = en;
	assign result.valid = vld_q[LAT-1];
	assign result.noise_value = acc[OCTAVES];
	assign acc[0] = VNF_ZERO;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], coord.valid};
		end
	end

	// Input stage: coordinates doubled k times for octave k.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < OCTAVES; k++) begin
				xs_s1[k] <= fp_scale(coord.x_coord, k);
				zs_s1[k] <= fp_scale(coord.z_coord, k);
			end
		end
	end

	// Octave k, its weight 0.5^(k+1), and the running sum in octave order.
	for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
		localparam vnf_word_t AMP = {1'b0, 8'(126 - k), 23'h0};

		vnf_octave u_oct (.clk(clk), .en(en), .x(xs_s1[k]), .z(zs_s1[k]), .y(nv[k]));
		vnf_fpu #(.OP(VNF_MUL)) u_wt (.clk(clk), .en(en), .a(AMP), .b(nv[k]), .y(wt[k]));
		vnf_delay #(.W(32), .D(VNF_FPU_LAT * k)) u_wt_d (
			.clk(clk), .en(en), .a(wt[k]), .y(wt_d[k]));
		vnf_fpu #(.OP(VNF_ADD)) u_acc (
			.clk(clk), .en(en), .a(acc[k]), .b(wt_d[k]), .y(acc[k+1]));
	end

`ifndef SYNTH
	// An advancing cycle loads the first valid bit from the input channel.
	a_vld_load: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (vld_q[0] == $past(coord.valid)))
		else $error("first valid bit did not follow the input channel");

	// A stalled cycle freezes every valid bit.
	a_vld_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (vld_q == $past(vld_q)))
		else $error("valid bits moved during a stall");

	// Any NaN result leaves in canonical form.
	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.noise_value[30:23] == 8'hFF) &&
		 (result.noise_value[22:0] != 23'h0)) |-> (result.noise_value == VNF_QNAN))
		else $error("non-canonical NaN on the result channel");
`endif
endmodule

`default_nettype wire

### rtl/core/vnf_fpu.sv
// ----------------------------------------------------------------------------
// vnf_fpu: two-stage single-precision add, subtract or multiply
// Stage one handles special cases and forms the raw sum or product;
// stage two normalizes and rounds to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_fpu #(
	parameter vnf_pkg::vnf_op_t OP = vnf_pkg::VNF_ADD
) (
	input  logic               clk,
	input  logic               en,
	input  vnf_pkg::vnf_word_t a,
	input  vnf_pkg::vnf_word_t b,
	output vnf_pkg::vnf_word_t y
);
	import vnf_pkg::*;

	vnf_unr_t  raw;
	vnf_unr_t  raw_s1;
	vnf_word_t y_s2;

	// Front half of the selected operation.
	always_comb begin
		case (OP)
			VNF_MUL: raw = fp_mul_a(a, b);
			VNF_SUB: raw = fp_add_a(a, b, 1'b1);
			default: raw = fp_add_a(a, b, 1'b0);
		endcase
	end

	// Both stages advance together with the rest of the pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= raw;
			y_s2 <= fp_fin(raw_s1);
		end
	end

	assign y = y_s2;
endmodule

`default_nettype wire

### rtl/core/vnf_floor.sv
// ----------------------------------------------------------------------------
// vnf_floor: one-stage single-precision floor
// Registers the exact IEEE floor of its operand.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_floor (
	input  logic               clk,
	input  logic               en,
	input  vnf_pkg::vnf_word_t a,
	output vnf_pkg::vnf_word_t y
);
	import vnf_pkg::*;

	vnf_word_t y_s1;

	// Floor by dropping the fraction bits, stepping negative non-integers down.
	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= fl_floor(a);
		end
	end

	assign y = y_s1;
endmodule

`default_nettype wire

### rtl/core/vnf_delay.sv
// ----------------------------------------------------------------------------
// vnf_delay: stallable delay line
// Holds an operand in a line of D registers so that it meets its partner in a later stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_delay #(
	parameter int W = 32,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] a,
	output logic [W-1:0] y
);
	generate
		if (D == 0) begin : g_none
			assign y = a;
		end else begin : g_line
			logic [W-1:0] line_q [D];

			// Shift one tap per advancing cycle.
			always_ff @(posedge clk) begin
				if (en) begin
					line_q[0] <= a;
					for (int i = 1; i < D; i++) begin
						line_q[i] <= line_q[i-1];
					end
				end
			end

			assign y = line_q[D-1];
		end
	endgenerate
endmodule

`default_nettype wire

### rtl/core/vnf_octave.sv
// ----------------------------------------------------------------------------
// vnf_octave: one octave of 2D value noise
// Floor and fraction, smoothing, four corner hashes and the bilinear blend,
// as a pipeline of floor stages and two-stage float units.
// ----------------------------------------------------------------------------
`default_nettype none

module vnf_octave (
	input  logic               clk,
	input  logic               en,
	input  vnf_pkg::vnf_word_t x,
	input  vnf_pkg::vnf_word_t z,
	output vnf_pkg::vnf_word_t y
);
	import vnf_pkg::*;

	vnf_word_t crd [2];
	vnf_word_t crd_d1 [2];
	vnf_word_t cell_fl [2];
	vnf_word_t cell_d3 [2];
	vnf_word_t cell1 [2];
	vnf_word_t frac [2];
	vnf_word_t sq [2];
	vnf_word_t tw [2];
	vnf_word_t kk [2];
	vnf_word_t sq_d [2];
	vnf_word_t sm [2];
	vnf_word_t lat [2][2];
	vnf_word_t hm [2][2];
	vnf_word_t hfl [2][2];
	vnf_word_t hm_d [2][2];
	vnf_word_t hf [2][2];
	vnf_word_t ta [2][2];
	vnf_word_t hf_d2 [2][2];
	vnf_word_t tm [2][2];
	vnf_word_t hf_d6 [2][2];
	vnf_word_t dd [4];
	vnf_word_t pp [4];
	vnf_word_t qq [4];
	vnf_word_t rr [4];
	vnf_word_t rfl [4];
	vnf_word_t rr_d [4];
	vnf_word_t cv [4];
	vnf_word_t ed, gd, em, gm, a_d, c_d, top, bot, hd, smx_d, smz_d, hz, top_d;

	assign crd[0] = x;
	assign crd[1] = z;

	// Per axis: lattice cell, fractional part and its smoothed weight.
	for (genvar ax = 0; ax < 2; ax++) begin : g_axis
		localparam vnf_word_t HK = (ax == 0) ? VNF_HASH_X : VNF_HASH_Z;

		vnf_floor u_cell (.clk(clk), .en(en), .a(crd[ax]), .y(cell_fl[ax]));
		vnf_delay #(.W(32), .D(1)) u_crd_d (.clk(clk), .en(en), .a(crd[ax]), .y(crd_d1[ax]));
		vnf_fpu #(.OP(VNF_SUB)) u_frac (
			.clk(clk), .en(en), .a(crd_d1[ax]), .b(cell_fl[ax]), .y(frac[ax]));
		vnf_fpu #(.OP(VNF_ADD)) u_cell1 (
			.clk(clk), .en(en), .a(cell_fl[ax]), .b(VNF_ONE), .y(cell1[ax]));
		vnf_delay #(.W(32), .D(2)) u_cell_d (
			.clk(clk), .en(en), .a(cell_fl[ax]), .y(cell_d3[ax]));

		// Smoothing t*t*(3-2t).
		vnf_fpu #(.OP(VNF_MUL)) u_sq (
			.clk(clk), .en(en), .a(frac[ax]), .b(frac[ax]), .y(sq[ax]));
		vnf_fpu #(.OP(VNF_MUL)) u_tw (
			.clk(clk), .en(en), .a(VNF_TWO), .b(frac[ax]), .y(tw[ax]));
		vnf_fpu #(.OP(VNF_SUB)) u_k (
			.clk(clk), .en(en), .a(VNF_THREE), .b(tw[ax]), .y(kk[ax]));
		vnf_delay #(.W(32), .D(2)) u_sq_d (.clk(clk), .en(en), .a(sq[ax]), .y(sq_d[ax]));
		vnf_fpu #(.OP(VNF_MUL)) u_sm (
			.clk(clk), .en(en), .a(sq_d[ax]), .b(kk[ax]), .y(sm[ax]));

		assign lat[ax][0] = cell_d3[ax];
		assign lat[ax][1] = cell1[ax];

		// Hash terms that depend on one coordinate only: h and h*(h+45.32).
		for (genvar li = 0; li < 2; li++) begin : g_lane
			vnf_fpu #(.OP(VNF_MUL)) u_hm (
				.clk(clk), .en(en), .a(lat[ax][li]), .b(HK), .y(hm[ax][li]));
			vnf_floor u_hfl (.clk(clk), .en(en), .a(hm[ax][li]), .y(hfl[ax][li]));
			vnf_delay #(.W(32), .D(1)) u_hm_d (
				.clk(clk), .en(en), .a(hm[ax][li]), .y(hm_d[ax][li]));
			vnf_fpu #(.OP(VNF_SUB)) u_hf (
				.clk(clk), .en(en), .a(hm_d[ax][li]), .b(hfl[ax][li]), .y(hf[ax][li]));
			vnf_fpu #(.OP(VNF_ADD)) u_ta (
				.clk(clk), .en(en), .a(hf[ax][li]), .b(VNF_HASH_OFS), .y(ta[ax][li]));
			vnf_delay #(.W(32), .D(2)) u_hf_d2 (
				.clk(clk), .en(en), .a(hf[ax][li]), .y(hf_d2[ax][li]));
			vnf_fpu #(.OP(VNF_MUL)) u_tm (
				.clk(clk), .en(en), .a(hf_d2[ax][li]), .b(ta[ax][li]), .y(tm[ax][li]));
			vnf_delay #(.W(32), .D(6)) u_hf_d6 (
				.clk(clk), .en(en), .a(hf[ax][li]), .y(hf_d6[ax][li]));
		end
	end

	// Corner hashes; corner c sits at x offset c%2 and z offset c/2.
	for (genvar c = 0; c < 4; c++) begin : g_corner
		localparam int XI = c % 2;
		localparam int ZI = c / 2;

		vnf_fpu #(.OP(VNF_ADD)) u_d (
			.clk(clk), .en(en), .a(tm[0][XI]), .b(tm[1][ZI]), .y(dd[c]));
		vnf_fpu #(.OP(VNF_ADD)) u_p (
			.clk(clk), .en(en), .a(hf_d6[0][XI]), .b(dd[c]), .y(pp[c]));
		vnf_fpu #(.OP(VNF_ADD)) u_q (
			.clk(clk), .en(en), .a(hf_d6[1][ZI]), .b(dd[c]), .y(qq[c]));
		vnf_fpu #(.OP(VNF_MUL)) u_r (
			.clk(clk), .en(en), .a(pp[c]), .b(qq[c]), .y(rr[c]));
		vnf_floor u_rfl (.clk(clk), .en(en), .a(rr[c]), .y(rfl[c]));
		vnf_delay #(.W(32), .D(1)) u_rr_d (.clk(clk), .en(en), .a(rr[c]), .y(rr_d[c]));
		vnf_fpu #(.OP(VNF_SUB)) u_cv (
			.clk(clk), .en(en), .a(rr_d[c]), .b(rfl[c]), .y(cv[c]));
	end

	// Blend along x, then along z.
	vnf_fpu #(.OP(VNF_SUB)) u_e (.clk(clk), .en(en), .a(cv[1]), .b(cv[0]), .y(ed));
	vnf_fpu #(.OP(VNF_SUB)) u_g (.clk(clk), .en(en), .a(cv[3]), .b(cv[2]), .y(gd));
	vnf_delay #(.W(32), .D(14)) u_smx_d (.clk(clk), .en(en), .a(sm[0]), .y(smx_d));
	vnf_fpu #(.OP(VNF_MUL)) u_em (.clk(clk), .en(en), .a(ed), .b(smx_d), .y(em));
	vnf_fpu #(.OP(VNF_MUL)) u_gm (.clk(clk), .en(en), .a(gd), .b(smx_d), .y(gm));
	vnf_delay #(.W(32), .D(4)) u_a_d (.clk(clk), .en(en), .a(cv[0]), .y(a_d));
	vnf_delay #(.W(32), .D(4)) u_c_d (.clk(clk), .en(en), .a(cv[2]), .y(c_d));
	vnf_fpu #(.OP(VNF_ADD)) u_top (.clk(clk), .en(en), .a(a_d), .b(em), .y(top));
	vnf_fpu #(.OP(VNF_ADD)) u_bot (.clk(clk), .en(en), .a(c_d), .b(gm), .y(bot));
	vnf_fpu #(.OP(VNF_SUB)) u_h (.clk(clk), .en(en), .a(bot), .b(top), .y(hd));
	vnf_delay #(.W(32), .D(20)) u_smz_d (.clk(clk), .en(en), .a(sm[1]), .y(smz_d));
	vnf_fpu #(.OP(VNF_MUL)) u_hz (.clk(clk), .en(en), .a(hd), .b(smz_d), .y(hz));
	vnf_delay #(.W(32), .D(4)) u_top_d (.clk(clk), .en(en), .a(top), .y(top_d));
	vnf_fpu #(.OP(VNF_ADD)) u_out (.clk(clk), .en(en), .a(top_d), .b(hz), .y(y));
endmodule

`default_nettype wire
